@@ hdl/ucd_pkg.sv @@
// ----------------------------------------------------------------------------
// ucd_pkg: shared types and constants of the UTF-8 code point decoder
// Byte classes, queue entry and result records, reset values.
// ----------------------------------------------------------------------------
package ucd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CP_W         = 21;
    localparam int unsigned LIMIT_W      = 16;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [CP_W-1:0]    REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 16'd4096;

    // class of one raw byte: ASCII, sequence lead, continuation or bad
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } t_byte_class;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_byte_class       cls;
        logic              last;
    } t_qent;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            point_valid;
        logic            end_of_text;
        logic            limit_hit;
    } t_result;

    function automatic t_byte_class classify(input logic [BYTE_W-1:0] b);
        t_byte_class c;
        if ((b & 8'h80) == 8'h00) begin
            c = CLS_ASCII;
        end else if ((b & 8'hC0) == 8'h80) begin
            c = CLS_CONT;
        end else if ((b & 8'hE0) == 8'hC0) begin
            c = CLS_LEAD2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            c = CLS_LEAD3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_BAD;
        end
        return c;
    endfunction

endpackage

@@ hdl/ucd_front.sv @@
// ----------------------------------------------------------------------------
// ucd_front: byte intake and classification
// Tag each accepted byte with its class and queue it for the decode stage.
// ----------------------------------------------------------------------------
module ucd_front #(
    parameter int unsigned QUEUE_DEPTH = ucd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [ucd_pkg::BYTE_W-1:0] i_s_axis_tdata,
    input  logic                       i_s_axis_tlast,
    output logic                       o_q_valid,
    output ucd_pkg::t_qent             o_q_data,
    input  logic                       i_q_pop
);
    import ucd_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_qent         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          push;
    t_qent         w_ent;

    assign o_s_axis_tready = (r_count != FULL_CNT);
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_count != '0);
    assign o_q_data        = r_mem[r_rd_ptr];

    always_comb begin
        w_ent.data = i_s_axis_tdata;
        w_ent.cls  = classify(i_s_axis_tdata);
        w_ent.last = i_s_axis_tlast;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= w_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/ucd_back.sv @@
// ----------------------------------------------------------------------------
// ucd_back: sequence decode and result register
// Hold pending bytes, decide at most one result per step, apply the code point limit.
// ----------------------------------------------------------------------------
module ucd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ucd_pkg::LIMIT_W-1:0] i_limit,
    input  logic                        i_q_valid,
    input  ucd_pkg::t_qent              i_q_data,
    output logic                        o_q_pop,
    output logic                        o_res_valid,
    output ucd_pkg::t_result            o_res,
    input  logic                        i_res_ready
);
    import ucd_pkg::*;

    t_qent               r_buf [3];
    t_qent               n_buf [3];
    logic [1:0]          r_len, n_len;
    logic                r_drain, n_drain;
    logic                r_last, n_last;
    logic [LIMIT_W-1:0]  r_emitted, n_emitted;
    logic                r_limit_flag, n_limit_flag;
    logic                r_out_valid;
    t_result             r_out;

    logic                out_free;
    logic                emit;
    t_result             res;

    assign out_free    = !r_out_valid || i_res_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        t_qent      v [4];
        logic [2:0] vlen;
        logic       vlast;
        logic [2:0] need;
        logic       bad_lead;
        logic       ok;
        logic [2:0] consumed;
        logic [2:0] rem;
        logic [2:0] sel;
        logic [CP_W-1:0] cp;

        n_buf        = r_buf;
        n_len        = r_len;
        n_drain      = r_drain;
        n_last       = r_last;
        n_emitted    = r_emitted;
        n_limit_flag = r_limit_flag;
        emit         = 1'b0;
        res          = '0;
        o_q_pop      = 1'b0;
        sel          = '0;

        // working view: pending bytes, plus the queue head when not draining
        for (int i = 0; i < 3; i++) begin
            v[i] = r_buf[i];
        end
        v[3] = '0;
        if (!r_drain) begin
            v[r_len] = i_q_data;
        end
        vlen  = r_drain ? {1'b0, r_len} : {1'b0, r_len} + 3'd1;
        vlast = r_drain ? r_last : i_q_data.last;

        need     = 3'd1;
        bad_lead = 1'b0;
        cp       = {13'd0, v[0].data};
        unique case (v[0].cls) inside
            CLS_ASCII: begin
                need = 3'd1;
                cp   = {13'd0, v[0].data};
            end
            CLS_LEAD2: begin
                need = 3'd2;
                cp   = {10'd0, v[0].data[4:0], v[1].data[5:0]};
            end
            CLS_LEAD3: begin
                need = 3'd3;
                cp   = {5'd0, v[0].data[3:0], v[1].data[5:0], v[2].data[5:0]};
            end
            CLS_LEAD4: begin
                need = 3'd4;
                cp   = {v[0].data[2:0], v[1].data[5:0], v[2].data[5:0],
                        v[3].data[5:0]};
            end
            CLS_CONT, CLS_BAD: begin
                bad_lead = 1'b1;
            end
            default: begin
                bad_lead = 1'b1;
            end
        endcase

        ok = 1'b1;
        for (int k = 1; k < 4; k++) begin
            if ((3'(k) < need) && (v[k].cls != CLS_CONT)) begin
                ok = 1'b0;
            end
        end

        consumed = (!bad_lead && ok) ? need : 3'd1;
        rem      = vlen - consumed;

        if (out_free && (r_drain || i_q_valid)) begin
            o_q_pop = !r_drain;
            if (!r_drain && r_limit_flag) begin
                // drop bytes until the end of the text, then flag the cut
                if (i_q_data.last) begin
                    emit              = 1'b1;
                    res.end_of_text   = 1'b1;
                    res.limit_hit     = 1'b1;
                    n_limit_flag      = 1'b0;
                    n_emitted         = '0;
                    n_len             = '0;
                end
            end else if (r_emitted >= i_limit) begin
                n_len   = '0;
                n_drain = 1'b0;
                if (vlast) begin
                    emit            = 1'b1;
                    res.end_of_text = 1'b1;
                    res.limit_hit   = 1'b1;
                    n_emitted       = '0;
                end else begin
                    n_limit_flag = 1'b1;
                end
            end else if (!bad_lead && (vlen < need)) begin
                n_drain = 1'b0;
                if (vlast) begin
                    // text cut inside a sequence
                    emit             = 1'b1;
                    res.code_point   = REPLACEMENT_CHAR;
                    res.point_valid  = 1'b1;
                    res.end_of_text  = 1'b1;
                    n_len            = '0;
                    n_emitted        = '0;
                end else begin
                    // hold the partial sequence for more bytes
                    n_len = vlen[1:0];
                    for (int i = 0; i < 3; i++) begin
                        n_buf[i] = v[i];
                    end
                end
            end else begin
                emit            = 1'b1;
                res.code_point  = (!bad_lead && ok) ? cp : REPLACEMENT_CHAR;
                res.point_valid = 1'b1;
                if (vlast && (rem == 3'd0)) begin
                    res.end_of_text = 1'b1;
                    n_len           = '0;
                    n_drain         = 1'b0;
                    n_emitted       = '0;
                end else begin
                    n_emitted = r_emitted + 1'b1;
                    n_len     = rem[1:0];
                    n_drain   = (rem != 3'd0);
                    n_last    = vlast;
                    for (int i = 0; i < 3; i++) begin
                        sel = 3'(i) + consumed;
                        n_buf[i] = (sel < 3'd4) ? v[sel[1:0]] : '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        n_buf_loop : for (int i = 0; i < 3; i++) begin
            r_buf[i] <= n_buf[i];
        end
        r_last <= n_last;
        if (emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_drain      <= 1'b0;
            r_emitted    <= '0;
            r_limit_flag <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_len        <= n_len;
            r_drain      <= n_drain;
            r_emitted    <= n_emitted;
            r_limit_flag <= n_limit_flag;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/utf8_codepoint_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder: UTF-8 byte stream to code point stream
// Top level: limit register, intake queue and decode stage.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a text enter on the s_axis channel, one request per byte, with
//   tlast on the final byte. Code points leave on the m_axis channel; tlast
//   marks the last result of a text, tuser[0] says the code point is real and
//   tuser[1] says the code point limit cut the text (end result only).
//   Malformed input yields U+FFFD; a text that ends inside a sequence yields
//   one U+FFFD as its last result.
//   The cfg channel writes the code point limit; it is always ready and must
//   only be written while no text is in flight.
// Throughput:
//   A byte passes through the intake queue, and its result through the output
//   register. The decode stage takes one step per cycle while the output
//   register is free: one byte per cycle in the normal case, plus a further
//   step for each further result released from the held bytes, such as the
//   replay after a bad continuation. A queue of QUEUE_DEPTH bytes absorbs
//   those extra steps.
// Reset and stalls:
//   Reset clears the queue, pending bytes, counters and sets the limit to
//   4096. When m_axis stalls the one-entry output register holds its result,
//   the decode stage waits, and the queue fills before s_axis tready drops.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder #(
    parameter int unsigned QUEUE_DEPTH = ucd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: code point limit
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ucd_pkg::LIMIT_W-1:0] i_cfg_data,
    // byte stream in
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] in_byte
    input  logic                        i_s_axis_tlast,   // last_byte
    // code point stream out
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [23:0]                 o_m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]                  o_m_axis_tuser,   // [0] point_valid, [1] limit_hit
    output logic                        o_m_axis_tlast    // end_of_text
);
    import ucd_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               q_valid;
    t_qent              q_data;
    logic               q_pop;
    t_result            res;

    // limit register: always accept a write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    ucd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_q_valid       (q_valid),
        .o_q_data        (q_data),
        .i_q_pop         (q_pop)
    );

    ucd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    // pack the result record onto the stream fields
    assign o_m_axis_tdata = {3'b000, res.code_point};
    assign o_m_axis_tuser = {res.limit_hit, res.point_valid};
    assign o_m_axis_tlast = res.end_of_text;

endmodule
